[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BES_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bus enumeration slave: assertion failed");

// next-cycle implication, checked out of reset
`define BES_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bus enumeration slave: assertion failed");

`endif

[design/bes_pkg.sv]
package bes_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_ABORT = 2'd1,
    OP_BYTE  = 2'd2,
    OP_SLOT  = 2'd3
  } op_t;

  // frame phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ADDR   = 3'd1,
    PH_ROM    = 3'd2,
    PH_ASSIGN = 3'd3,
    PH_METHOD = 3'd4,
    PH_KEY    = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  localparam logic [7:0]  ADDR_BROADCAST = 8'hFE;
  localparam logic [7:0]  METHOD_UNENUM  = 8'hFF;
  localparam logic [7:0]  LINE_RELEASED  = 8'hFF;
  localparam logic [31:0] KEY_RESET      = 32'hC107_2701;

  // largest descriptor store supported
  localparam int DESC_ROM_MAX = 512;

  // device descriptor contents, unlisted entries are zero
  localparam logic [7:0] DESC_ROM [DESC_ROM_MAX] = '{
    0: 8'h3A, 1: 8'h91, 2: 8'h5C, 3: 8'h0E, 4: 8'hD4, 5: 8'h27, 6: 8'h68, 7: 8'hB3,
    8: 8'h1F, 9: 8'h82, 10: 8'h4D, 11: 8'hE6, 12: 8'h70, 13: 8'h09, 14: 8'hAB,
    15: 8'hC5, 16: 8'h04, 17: 8'h01, 18: 8'h10, 19: 8'h00, 20: 8'h2A,
    default: 8'h00
  };

  // descriptor length: length entry plus id bytes plus one, capped at the depth
  function automatic int rom_length(int uuid, int depth);
    int entry;
    int len;
    entry = (uuid < depth) ? int'(DESC_ROM[uuid]) : 0;
    len   = entry + uuid + 1;
    return (len > depth) ? depth : len;
  endfunction

  // one result beat
  typedef struct packed {
    logic       ack;
    logic [7:0] drive_byte;
    logic       collision;
    logic       command_valid;
    logic [7:0] command;
    logic [7:0] own_address;
    logic       reset_done;
    logic [2:0] phase;
  } result_t;

endpackage

[design/bes_rom.sv]
module bes_rom #(
  parameter int ROM_DEPTH = 512,
  localparam int AW = $clog2(ROM_DEPTH),
  localparam int CW = $clog2(ROM_DEPTH + 1)
) (
  input  logic          clk,
  input  logic [CW-1:0] addr,
  output logic [7:0]    rdata
);
  import bes_pkg::*;

  // synchronous descriptor read, entries past the end read as zero
  always_ff @(posedge clk) begin
    if (addr < CW'(ROM_DEPTH)) begin
      rdata <= DESC_ROM[addr[AW-1:0]];
    end else begin
      rdata <= 8'h00;
    end
  end

endmodule

[design/bes_ctrl.sv]
module bes_ctrl #(
  parameter int ROM_DEPTH = 512,
  parameter int UUID_BYTES = 16,
  localparam int CW = $clog2(ROM_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [1:0]       operation,
  input  logic [7:0]       data,
  input  logic [31:0]      reset_key,
  input  logic [7:0]       rom_data,
  output logic [CW-1:0]    rom_addr,
  output bes_pkg::result_t res
);
  import bes_pkg::*;

  localparam int ROM_LEN = rom_length(UUID_BYTES, ROM_DEPTH);

  phase_t        phase_reg, phase_next;
  logic [7:0]    address_reg, address_next;
  logic [CW-1:0] rom_index, rom_index_next;
  logic [1:0]    key_index, key_index_next;
  logic          key_match, key_match_next;

  op_t           op;
  logic [CW-1:0] rom_inc;
  logic [7:0]    lost;
  logic [7:0]    smear;
  logic [3:0][7:0] key_bytes;
  logic [7:0]    key_byte;
  logic          match_now;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= PH_IDLE;
      address_reg <= 8'h00;
      rom_index   <= '0;
      key_index   <= 2'd0;
      key_match   <= 1'b1;
    end else begin
      phase_reg   <= phase_next;
      address_reg <= address_next;
      rom_index   <= rom_index_next;
      key_index   <= key_index_next;
      key_match   <= key_match_next;
    end
  end

  // prefetch the descriptor byte for the next slot
  assign rom_addr = rst ? '0 : rom_index_next;

  // arbitration: smear the lost bits downward from the highest one
  assign op      = op_t'(operation);
  assign rom_inc = rom_index + CW'(1);
  assign lost    = rom_data & ~data;
  always_comb begin
    smear[7] = lost[7];
    for (int i = 6; i >= 0; i--) begin
      smear[i] = smear[i+1] | lost[i];
    end
  end

  // key byte for this beat, first byte in the top bits
  assign key_bytes = reset_key;
  assign key_byte  = key_bytes[~key_index];
  assign match_now = key_match & (key_byte == data);

  // next state and result
  always_comb begin
    phase_next     = phase_reg;
    address_next   = address_reg;
    rom_index_next = rom_index;
    key_index_next = key_index;
    key_match_next = key_match;
    res            = '0;
    res.drive_byte = LINE_RELEASED;

    if (fire) begin
      unique case (op)
        OP_START: begin
          phase_next     = PH_ADDR;
          rom_index_next = '0;
          key_index_next = 2'd0;
          key_match_next = 1'b1;
        end
        OP_ABORT: begin
          phase_next = PH_IDLE;
        end
        OP_BYTE: begin
          unique case (phase_reg)
            PH_ADDR: begin
              if (data == address_reg) begin
                res.ack = 1'b1;
                if (data == 8'h00) begin
                  phase_next     = PH_ROM;
                  rom_index_next = '0;
                end else begin
                  phase_next = PH_METHOD;
                end
              end else if (data == ADDR_BROADCAST) begin
                res.ack        = 1'b1;
                phase_next     = PH_KEY;
                key_index_next = 2'd0;
                key_match_next = 1'b1;
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_ASSIGN: begin
              res.ack = 1'b1;
              if (data < ADDR_BROADCAST) begin
                address_next = data;
              end
              phase_next = PH_DONE;
            end
            PH_METHOD: begin
              res.ack = 1'b1;
              if (data == METHOD_UNENUM) begin
                address_next = 8'h00;
              end else begin
                res.command_valid = 1'b1;
                res.command       = data;
              end
              phase_next = PH_DONE;
            end
            PH_KEY: begin
              res.ack        = 1'b1;
              key_match_next = match_now;
              if (key_index == 2'd3) begin
                if (match_now) begin
                  address_next   = 8'h00;
                  res.reset_done = 1'b1;
                end
                key_index_next = 2'd0;
                phase_next     = PH_DONE;
              end else begin
                key_index_next = key_index + 2'd1;
              end
            end
            default: begin
            end
          endcase
        end
        OP_SLOT: begin
          if (phase_reg == PH_ROM) begin
            if (lost != 8'h00) begin
              res.drive_byte = rom_data | (smear >> 1);
              res.collision  = 1'b1;
              phase_next     = PH_DONE;
            end else begin
              res.drive_byte = rom_data;
              rom_index_next = rom_inc;
              if (rom_inc >= CW'(ROM_LEN)) begin
                phase_next = PH_ASSIGN;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    res.own_address = address_next;
    res.phase       = phase_next;
  end

endmodule

[design/bus_enumeration_slave.sv]
// Bus enumeration slave, byte level.
// Input channel (in_valid/in_ready, operation, data): one beat per bus event,
//   frame start, frame abort, a master byte or a sensed descriptor slot byte.
// Output channel (out_valid/out_ready): exactly one result beat per input beat,
//   in order: ack, drive_byte, collision, command_valid, command,
//   own_address, reset_done and the phase after the event.
// Config channel (cfg_valid/cfg_ready, cfg_data): 32-bit broadcast reset key,
//   always ready; users write it only while no beat is in flight, unenforced.
// Each result is registered and presented in the cycle after its beat is taken.
// Throughput: one beat per cycle unless stalled. The descriptor memory is read
//   ahead at the index the next slot will use, so every slot finds its byte.
// Stall: a single output register holds the result; while it is full and
//   out_ready is low, in_ready drops and the state stays put.
// Reset: phase idle, address 0 (unenumerated), key at its default value, no
//   result pending; the descriptor prefetch restarts at entry 0.
`include "assert_macros.svh"

module bus_enumeration_slave #(
  parameter int ROM_DEPTH = 512,
  parameter int UUID_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ack,
  output logic [7:0]  drive_byte,
  output logic        collision,
  output logic        command_valid,
  output logic [7:0]  command,
  output logic [7:0]  own_address,
  output logic        reset_done,
  output logic [2:0]  phase,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import bes_pkg::*;

  localparam int CW = $clog2(ROM_DEPTH + 1);

  logic          fire;
  logic [31:0]   reset_key;
  logic [CW-1:0] rom_addr;
  logic [7:0]    rom_data;
  result_t       res;
  result_t       res_q;

  // handshakes
  assign in_ready  = !out_valid || out_ready;
  assign fire      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // reset key register
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_key <= KEY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      reset_key <= cfg_data;
    end
  end

  // descriptor memory
  bes_rom #(
    .ROM_DEPTH(ROM_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .rdata(rom_data)
  );

  // frame control
  bes_ctrl #(
    .ROM_DEPTH (ROM_DEPTH),
    .UUID_BYTES(UUID_BYTES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .operation(operation),
    .data     (data),
    .reset_key(reset_key),
    .rom_data (rom_data),
    .rom_addr (rom_addr),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign ack           = res_q.ack;
  assign drive_byte    = res_q.drive_byte;
  assign collision     = res_q.collision;
  assign command_valid = res_q.command_valid;
  assign command       = res_q.command;
  assign own_address   = res_q.own_address;
  assign reset_done    = res_q.reset_done;
  assign phase         = res_q.phase;

  // checks
  `BES_ASSERT_IMP(a_coll_ends_frame, out_valid && collision, phase == PH_DONE)
  `BES_ASSERT_IMP(a_key_reset_clears, out_valid && reset_done, own_address == 8'h00)
  `BES_ASSERT_IMP(a_cmd_not_unenum, out_valid && command_valid, command != METHOD_UNENUM)
  `BES_ASSERT_NXT(a_start_addr, fire && (operation == OP_START),
                  out_valid && (phase == PH_ADDR))

endmodule
